[hw/rtl/jsvt_pkg.sv]
// shared types, event and error codes for the json tokenizer
`timescale 1ns / 1ps

package jsvt_pkg;

    localparam int MAX_RES = 5;

    localparam logic [4:0] EV_OBJ_OPEN   = 5'd0;
    localparam logic [4:0] EV_OBJ_CLOSE  = 5'd1;
    localparam logic [4:0] EV_ARR_OPEN   = 5'd2;
    localparam logic [4:0] EV_ARR_CLOSE  = 5'd3;
    localparam logic [4:0] EV_KEY_BEGIN  = 5'd4;
    localparam logic [4:0] EV_KEY_BYTE   = 5'd5;
    localparam logic [4:0] EV_KEY_END    = 5'd6;
    localparam logic [4:0] EV_STR_BEGIN  = 5'd7;
    localparam logic [4:0] EV_STR_BYTE   = 5'd8;
    localparam logic [4:0] EV_STR_END    = 5'd9;
    localparam logic [4:0] EV_NUM_BYTE   = 5'd10;
    localparam logic [4:0] EV_NUM_END    = 5'd11;
    localparam logic [4:0] EV_TRUE       = 5'd12;
    localparam logic [4:0] EV_FALSE      = 5'd13;
    localparam logic [4:0] EV_NULL       = 5'd14;
    localparam logic [4:0] EV_ACCEPT     = 5'd15;
    localparam logic [4:0] EV_ERROR      = 5'd16;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_UNEXP     = 4'd1;
    localparam logic [3:0] ERR_DEPTH     = 4'd2;
    localparam logic [3:0] ERR_CTRL      = 4'd3;
    localparam logic [3:0] ERR_ESCAPE    = 4'd4;
    localparam logic [3:0] ERR_HEX       = 4'd5;
    localparam logic [3:0] ERR_SURR      = 4'd6;
    localparam logic [3:0] ERR_TRUNC     = 4'd7;
    localparam logic [3:0] ERR_TRAIL     = 4'd8;

    typedef struct packed {
        logic [7:0] doc_byte;
        logic       doc_end;
    } in_item_t;

    typedef struct packed {
        logic [4:0] event_res;
        logic [7:0] data_out;
        logic [5:0] nest_level;
        logic [3:0] error_code;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                n;
        out_item_t [MAX_RES-1:0]   ev;
    } bundle_t;

    // expected letters after t, f, n: "rue" "alse" "ull"
    function automatic logic [7:0] lit_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h72;
            4'd1:    c = 8'h75;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h61;
            4'd4:    c = 8'h6c;
            4'd5:    c = 8'h73;
            4'd6:    c = 8'h65;
            4'd7:    c = 8'h75;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h6c;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/jsvt_front.sv]
// front end: grammar state, nesting stack, per-byte event bundle
`timescale 1ns / 1ps

module jsvt_front
    import jsvt_pkg::*;
#(
    parameter int MAX_NEST = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_item_t   in_item,
    input  logic [5:0] max_depth,
    output logic       bnd_valid,
    output bundle_t    bnd
);

    localparam int CNT_W = $clog2(MAX_NEST + 1);
    localparam int IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    typedef enum logic [21:0] {
        M_VALUE     = 22'h000001,
        M_ARR_FIRST = 22'h000002,
        M_OBJ_FIRST = 22'h000004,
        M_KEY       = 22'h000008,
        M_COLON     = 22'h000010,
        M_AFTER     = 22'h000020,
        M_DONE      = 22'h000040,
        M_STR       = 22'h000080,
        M_ESC       = 22'h000100,
        M_HEX       = 22'h000200,
        M_HEX_LO    = 22'h000400,
        M_SUR_BS    = 22'h000800,
        M_SUR_U     = 22'h001000,
        M_N_MINUS   = 22'h002000,
        M_N_ZERO    = 22'h004000,
        M_N_INT     = 22'h008000,
        M_N_DOT     = 22'h010000,
        M_N_FRAC    = 22'h020000,
        M_N_E       = 22'h040000,
        M_N_ESIGN   = 22'h080000,
        M_N_EXP     = 22'h100000,
        M_LIT       = 22'h200000
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] cnt;
        logic             in_key;
        logic [15:0]      hex;
        logic [1:0]       hexn;
        logic [9:0]       hs;
        logic [3:0]       lit;
        logic             failed;
    } pstate_t;

    typedef struct packed {
        pstate_t         st;
        logic            refeed;
        logic [2:0]      n;
        out_item_t [3:0] ev;
        logic            push_en;
        logic            push_kind;
    } feed_out_t;

    pstate_t st_reg, st_next;
    logic    stack_reg [MAX_NEST];

    logic             top_obj;
    logic             top_ok;
    logic             open_ok;
    logic [6:0]       limit;
    logic [CNT_W-1:0] cnt_m1;
    feed_out_t        f1, f2;
    logic             use2;

    function automatic void add(inout feed_out_t r, input logic [4:0] ev,
                                input logic [7:0] d, input logic [3:0] c);
        r.ev[r.n[1:0]] = '{event_res: ev, data_out: d, nest_level: 6'(r.st.cnt),
                           error_code: c, run_last: 1'b0};
        r.n = r.n + 3'd1;
    endfunction

    function automatic void fail(inout feed_out_t r, input logic [3:0] c);
        r.st.failed = 1'b1;
        add(r, EV_ERROR, 8'd0, c);
    endfunction

    function automatic void value_done(inout feed_out_t r);
        r.st.mode = (r.st.cnt != '0) ? M_AFTER : M_DONE;
    endfunction

    function automatic void str_byte(inout feed_out_t r, input logic [7:0] b);
        add(r, r.st.in_key ? EV_KEY_BYTE : EV_STR_BYTE, b, ERR_NONE);
    endfunction

    function automatic void emit_utf8(inout feed_out_t r, input logic [20:0] cp);
        if (cp < 21'h80) begin
            str_byte(r, cp[7:0]);
        end else if (cp < 21'h800) begin
            str_byte(r, {3'b110, cp[10:6]});
            str_byte(r, {2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            str_byte(r, {4'b1110, cp[15:12]});
            str_byte(r, {2'b10, cp[11:6]});
            str_byte(r, {2'b10, cp[5:0]});
        end else begin
            str_byte(r, {5'b11110, cp[20:18]});
            str_byte(r, {2'b10, cp[17:12]});
            str_byte(r, {2'b10, cp[11:6]});
            str_byte(r, {2'b10, cp[5:0]});
        end
    endfunction

    function automatic void open_nest(inout feed_out_t r, input logic kind, input logic ok);
        if (!ok) begin
            fail(r, ERR_DEPTH);
        end else begin
            r.push_en   = 1'b1;
            r.push_kind = kind;
            r.st.cnt    = r.st.cnt + CNT_W'(1);
            add(r, kind ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'd0, ERR_NONE);
            r.st.mode = kind ? M_OBJ_FIRST : M_ARR_FIRST;
        end
    endfunction

    function automatic void close_nest(inout feed_out_t r, input logic kind,
                                       input logic tobj, input logic tok);
        if (!tok || (tobj != kind)) begin
            fail(r, ERR_UNEXP);
        end else begin
            r.st.cnt = r.st.cnt - CNT_W'(1);
            add(r, kind ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'd0, ERR_NONE);
            value_done(r);
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) v = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) v = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) v = {1'b1, 4'(b - 8'h37)};
        else v = 5'd0;
        return v;
    endfunction

    function automatic void start_value(inout feed_out_t r, input logic [7:0] b,
                                        input logic ok);
        if (b == 8'h7b) open_nest(r, 1'b1, ok);
        else if (b == 8'h5b) open_nest(r, 1'b0, ok);
        else if (b == 8'h22) begin
            r.st.in_key = 1'b0;
            add(r, EV_STR_BEGIN, 8'd0, ERR_NONE);
            r.st.mode = M_STR;
        end else if (b == 8'h2d) begin
            add(r, EV_NUM_BYTE, b, ERR_NONE);
            r.st.mode = M_N_MINUS;
        end else if (b == 8'h30) begin
            add(r, EV_NUM_BYTE, b, ERR_NONE);
            r.st.mode = M_N_ZERO;
        end else if (is_digit(b)) begin
            add(r, EV_NUM_BYTE, b, ERR_NONE);
            r.st.mode = M_N_INT;
        end else if (b == 8'h74) begin
            r.st.lit  = 4'd0;
            r.st.mode = M_LIT;
        end else if (b == 8'h66) begin
            r.st.lit  = 4'd3;
            r.st.mode = M_LIT;
        end else if (b == 8'h6e) begin
            r.st.lit  = 4'd7;
            r.st.mode = M_LIT;
        end else fail(r, ERR_UNEXP);
    endfunction

    function automatic feed_out_t feed(input pstate_t s, input logic [7:0] b,
                                       input logic tobj, input logic tok, input logic ok);
        feed_out_t   r;
        logic [4:0]  hv;
        logic [15:0] acc;
        logic [20:0] cp;
        r.st        = s;
        r.refeed    = 1'b0;
        r.n         = 3'd0;
        r.ev        = '0;
        r.push_en   = 1'b0;
        r.push_kind = 1'b0;
        hv          = hex_val(b);
        acc         = {s.hex[11:0], hv[3:0]};
        cp          = 21'h10000 + {1'b0, s.hs, acc[9:0]};
        unique case (s.mode)
            M_VALUE, M_ARR_FIRST: begin
                if (!is_ws(b)) begin
                    if (s.mode == M_ARR_FIRST && b == 8'h5d) close_nest(r, 1'b0, tobj, tok);
                    else start_value(r, b, ok);
                end
            end
            M_OBJ_FIRST, M_KEY: begin
                if (!is_ws(b)) begin
                    if (b == 8'h22) begin
                        r.st.in_key = 1'b1;
                        add(r, EV_KEY_BEGIN, 8'd0, ERR_NONE);
                        r.st.mode = M_STR;
                    end else if (s.mode == M_OBJ_FIRST && b == 8'h7d) begin
                        close_nest(r, 1'b1, tobj, tok);
                    end else fail(r, ERR_UNEXP);
                end
            end
            M_COLON: begin
                if (!is_ws(b)) begin
                    if (b == 8'h3a) r.st.mode = M_VALUE;
                    else fail(r, ERR_UNEXP);
                end
            end
            M_AFTER: begin
                if (!is_ws(b)) begin
                    if (b == 8'h2c) r.st.mode = (tok && tobj) ? M_KEY : M_VALUE;
                    else if (b == 8'h7d) close_nest(r, 1'b1, tobj, tok);
                    else if (b == 8'h5d) close_nest(r, 1'b0, tobj, tok);
                    else fail(r, ERR_UNEXP);
                end
            end
            M_DONE: begin
                if (!is_ws(b)) fail(r, ERR_TRAIL);
            end
            M_STR: begin
                if (b == 8'h22) begin
                    add(r, s.in_key ? EV_KEY_END : EV_STR_END, 8'd0, ERR_NONE);
                    if (s.in_key) begin
                        r.st.in_key = 1'b0;
                        r.st.mode   = M_COLON;
                    end else value_done(r);
                end else if (b < 8'h20) fail(r, ERR_CTRL);
                else if (b == 8'h5c) r.st.mode = M_ESC;
                else str_byte(r, b);
            end
            M_ESC: begin
                r.st.mode = M_STR;
                case (b)
                    8'h22: str_byte(r, 8'h22);
                    8'h5c: str_byte(r, 8'h5c);
                    8'h2f: str_byte(r, 8'h2f);
                    8'h62: str_byte(r, 8'h08);
                    8'h66: str_byte(r, 8'h0c);
                    8'h6e: str_byte(r, 8'h0a);
                    8'h72: str_byte(r, 8'h0d);
                    8'h74: str_byte(r, 8'h09);
                    8'h75: begin
                        r.st.hex  = 16'd0;
                        r.st.hexn = 2'd0;
                        r.st.mode = M_HEX;
                    end
                    default: fail(r, ERR_ESCAPE);
                endcase
            end
            M_HEX, M_HEX_LO: begin
                if (!hv[4]) begin
                    fail(r, ERR_HEX);
                end else begin
                    r.st.hex = acc;
                    if (s.hexn != 2'd3) begin
                        r.st.hexn = s.hexn + 2'd1;
                    end else begin
                        r.st.hexn = 2'd0;
                        if (s.mode == M_HEX) begin
                            if (acc >= 16'hd800 && acc <= 16'hdbff) begin
                                r.st.hs   = acc[9:0];
                                r.st.mode = M_SUR_BS;
                            end else if (acc >= 16'hdc00 && acc <= 16'hdfff) begin
                                fail(r, ERR_SURR);
                            end else begin
                                emit_utf8(r, {5'd0, acc});
                                r.st.mode = M_STR;
                            end
                        end else begin
                            if (acc >= 16'hdc00 && acc <= 16'hdfff) begin
                                emit_utf8(r, cp);
                                r.st.mode = M_STR;
                            end else fail(r, ERR_SURR);
                        end
                    end
                end
            end
            M_SUR_BS: begin
                if (b == 8'h5c) r.st.mode = M_SUR_U;
                else fail(r, ERR_SURR);
            end
            M_SUR_U: begin
                if (b == 8'h75) begin
                    r.st.hex  = 16'd0;
                    r.st.hexn = 2'd0;
                    r.st.mode = M_HEX_LO;
                end else fail(r, ERR_SURR);
            end
            M_N_MINUS: begin
                if (b == 8'h30) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_ZERO;
                end else if (is_digit(b)) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_INT;
                end else fail(r, ERR_UNEXP);
            end
            M_N_ZERO, M_N_INT, M_N_FRAC: begin
                if (is_digit(b) && s.mode != M_N_ZERO) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                end else if (b == 8'h2e && s.mode != M_N_FRAC) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_DOT;
                end else if (b == 8'h65 || b == 8'h45) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_E;
                end else begin
                    add(r, EV_NUM_END, 8'd0, ERR_NONE);
                    value_done(r);
                    r.refeed = 1'b1;
                end
            end
            M_N_DOT: begin
                if (is_digit(b)) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_FRAC;
                end else fail(r, ERR_UNEXP);
            end
            M_N_E: begin
                if (b == 8'h2b || b == 8'h2d) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_ESIGN;
                end else if (is_digit(b)) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_EXP;
                end else fail(r, ERR_UNEXP);
            end
            M_N_ESIGN: begin
                if (is_digit(b)) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                    r.st.mode = M_N_EXP;
                end else fail(r, ERR_UNEXP);
            end
            M_N_EXP: begin
                if (is_digit(b)) begin
                    add(r, EV_NUM_BYTE, b, ERR_NONE);
                end else begin
                    add(r, EV_NUM_END, 8'd0, ERR_NONE);
                    value_done(r);
                    r.refeed = 1'b1;
                end
            end
            M_LIT: begin
                if (s.lit >= 4'd10 || b != lit_char(s.lit)) fail(r, ERR_UNEXP);
                else if (s.lit == 4'd2) begin
                    add(r, EV_TRUE, 8'd0, ERR_NONE);
                    value_done(r);
                end else if (s.lit == 4'd6) begin
                    add(r, EV_FALSE, 8'd0, ERR_NONE);
                    value_done(r);
                end else if (s.lit == 4'd9) begin
                    add(r, EV_NULL, 8'd0, ERR_NONE);
                    value_done(r);
                end else r.st.lit = s.lit + 4'd1;
            end
            default: fail(r, ERR_UNEXP);
        endcase
        return r;
    endfunction

    function automatic void append(inout bundle_t bb, input out_item_t it);
        if (bb.n < 3'(MAX_RES)) begin
            bb.ev[bb.n] = it;
            bb.n        = bb.n + 3'd1;
        end
    endfunction

    assign cnt_m1  = st_reg.cnt - CNT_W'(1);
    assign top_ok  = (st_reg.cnt != '0);
    assign top_obj = stack_reg[cnt_m1[IDX_W-1:0]];
    assign limit   = (7'(max_depth) < 7'(MAX_NEST)) ? 7'(max_depth) : 7'(MAX_NEST);
    assign open_ok = (7'(st_reg.cnt) < limit);

    always_comb
    begin
        pstate_t   s2;
        out_item_t it;
        f1   = feed(st_reg, in_item.doc_byte, top_obj, top_ok, open_ok);
        f2   = feed(f1.st, in_item.doc_byte, top_obj, top_ok, open_ok);
        use2 = f1.refeed && !f1.st.failed;
        s2   = use2 ? f2.st : f1.st;
        bnd.n  = 3'd0;
        bnd.ev = '0;
        it     = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < f1.n) append(bnd, f1.ev[i]);
        end
        if (use2) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < f2.n) append(bnd, f2.ev[i]);
            end
        end
        if (in_item.doc_end && !s2.failed) begin
            if (s2.mode == M_N_ZERO || s2.mode == M_N_INT ||
                s2.mode == M_N_FRAC || s2.mode == M_N_EXP) begin
                it = '{event_res: EV_NUM_END, data_out: 8'd0, nest_level: 6'(s2.cnt),
                       error_code: ERR_NONE, run_last: 1'b0};
                append(bnd, it);
                s2.mode = (s2.cnt != '0) ? M_AFTER : M_DONE;
            end
            if (s2.mode == M_DONE)
                it = '{event_res: EV_ACCEPT, data_out: 8'd0, nest_level: 6'(s2.cnt),
                       error_code: ERR_NONE, run_last: 1'b0};
            else
                it = '{event_res: EV_ERROR, data_out: 8'd0, nest_level: 6'(s2.cnt),
                       error_code: ERR_TRUNC, run_last: 1'b0};
            append(bnd, it);
        end
        if (st_reg.failed) begin
            bnd.n = 3'd0;
            s2    = st_reg;
        end
        if (bnd.n != 3'd0) bnd.ev[bnd.n - 3'd1].run_last = 1'b1;
        if (in_item.doc_end) begin
            s2.mode   = M_VALUE;
            s2.cnt    = '0;
            s2.in_key = 1'b0;
            s2.hex    = 16'd0;
            s2.hexn   = 2'd0;
            s2.hs     = 10'd0;
            s2.lit    = 4'd0;
            s2.failed = 1'b0;
        end
        st_next   = s2;
        bnd_valid = fire && (bnd.n != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode   <= M_VALUE;
            st_reg.cnt    <= '0;
            st_reg.in_key <= 1'b0;
            st_reg.hex    <= 16'd0;
            st_reg.hexn   <= 2'd0;
            st_reg.hs     <= 10'd0;
            st_reg.lit    <= 4'd0;
            st_reg.failed <= 1'b0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // nesting kinds, 1 object 0 array
    always_ff @(posedge clk)
    begin
        if (fire && !st_reg.failed && f1.push_en)
        begin
            stack_reg[st_reg.cnt[IDX_W-1:0]] <= f1.push_kind;
        end
    end

endmodule

[hw/rtl/jsvt_back.sv]
// back end: bundle queue and one-event-per-cycle result drain while pop is high
`timescale 1ns / 1ps

module jsvt_back
    import jsvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  bundle_t   wr_data,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    bundle_t        mem_reg [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [PW:0]    cnt_reg, cnt_next;
    logic [2:0]     sub_reg, sub_next;
    bundle_t        head;
    logic           take;
    logic           drop;

    assign head     = mem_reg[rptr_reg];
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (PW+1)'(DEPTH));
    assign out_item = head.ev[sub_reg];
    assign take     = pop && !empty;
    assign drop     = take && (sub_reg == head.n - 3'd1);

    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next = drop ? rptr_reg + PW'(1) : rptr_reg;
        sub_next  = drop ? 3'd0 : (take ? sub_reg + 3'd1 : sub_reg);
        cnt_next  = cnt_reg + (PW+1)'(wr_en) - (PW+1)'(drop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
            sub_reg  <= 3'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/json_stream_validating_tokenizer.sv]
// top level: streaming json tokenizer and validator
//
// channel   dir  handshake          payload
// input     in   push / full        in_item  (doc_byte, doc_end)
// result    out  empty / pop        out_item (event_res .. run_last)
// config    in   cfg_valid / ready  cfg_data (max_depth)
//
// one byte a request per cycle while full is low; the front grammar logic handles each byte combinationally
// a byte makes zero to five events, queued as one bundle in a four-entry queue
// the result side drains one event per cycle while pop is high, so bytes with many events set the pace
// full rises only when four bundles wait, and then every byte waits; silent bytes add no bundle
// reset clears parser state and sets max_depth to 32; no clearing pass
`timescale 1ns / 1ps

module json_stream_validating_tokenizer
    import jsvt_pkg::*;
#(
    parameter int MAX_NEST = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   in_item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

    logic [5:0] max_depth_reg;
    logic       fire;
    logic       bnd_valid;
    bundle_t    bnd;

    assign cfg_ready = 1'b1;
    assign fire      = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_depth_reg <= cfg_data;
        end
    end

    jsvt_front #(.MAX_NEST(MAX_NEST)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_item   (in_item),
        .max_depth (max_depth_reg),
        .bnd_valid (bnd_valid),
        .bnd       (bnd)
    );

    jsvt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (bnd_valid),
        .wr_data  (bnd),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while empty");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.event_res == EV_ACCEPT || out_item.event_res == EV_ERROR))
        |-> out_item.run_last)
        else $error("accept or error not last of its byte");

    a_code_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((out_item.error_code != ERR_NONE) == (out_item.event_res == EV_ERROR)))
        else $error("error code mismatch");

endmodule
